// ===== rtl/bspl_pkg.sv =====
// Shared types and constants for the cubic B-spline evaluator.
// Used by the point store, the fetch sequencer, the datapath and the top level.
`default_nettype none

package bspl_pkg;

    // Point store geometry. The index wraps modulo the depth, so the depth
    // is a power of two and the address is the low bits of the index.
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int IDX_W      = 6;

    // Input beat kinds, selected by the mode field.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // Curve parameter: unsigned fraction with T_BITS bits.
    localparam int T_BITS   = 16;
    localparam int PARAM_W  = 16;
    localparam int U_W      = T_BITS + 1;

    localparam int COORD_W  = 16;
    localparam int N_AXES   = 3;
    localparam int OUT_W    = 24;

    // Datapath widths. Every polynomial coefficient fits in 20 signed bits.
    localparam int C_W      = 20;
    localparam int M1_W     = C_W + U_W;
    localparam int A1_W     = C_W + T_BITS + 2;
    localparam int M2_W     = A1_W + U_W;
    localparam int A2_W     = M2_W + 1;
    localparam int M3_W     = A2_W + U_W;
    localparam int S2_W     = 2 * T_BITS + 1 + OUT_W;

    // Position division by six: the unscaled sum lies in [-6*2^15, 6*2^15),
    // so an offset makes it a 19-bit unsigned value that is divided by a
    // reciprocal multiply, then the offset over six is taken back out.
    localparam int W_W      = 19;
    localparam int POS_OFF  = 6 * 32768;
    localparam int POS_BIAS = 32768;
    localparam int RECIP_SH = 22;
    localparam int RECIP_W  = 20;
    localparam int RECIP    = ((1 << RECIP_SH) + 5) / 6;
    localparam int Q_W      = W_W + RECIP_W;
    localparam int Q_OUT_W  = Q_W - RECIP_SH;

    typedef logic signed [COORD_W-1:0] t_coord;
    // Element 0 is x, 1 is y, 2 is z.
    typedef t_coord [N_AXES-1:0] t_point;
    typedef logic [N_AXES-1:0][OUT_W-1:0] t_vec3;

    // One access of the single-port point store.
    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_point            wdata;
    } t_mem_req;

    // Four gathered control points and the parameter, handed to the datapath.
    typedef struct packed {
        logic              valid;
        t_point [3:0]      pts;
        logic [T_BITS-1:0] u;
    } t_seg;

    typedef struct packed {
        t_vec3 pos;
        t_vec3 slope;
        t_vec3 bend;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/cubic_bspline_evaluator.sv =====
// Top level of the uniform cubic B-spline evaluator.
// Instantiates bspl_store, bspl_fetch and bspl_datapath; uses bspl_pkg.
//
// Input channel (i_in_valid / o_in_ready): a beat with i_in_mode low writes
// one Q8.8 control point to slot i_in_index and gives no result; a beat with
// i_in_mode high evaluates the segment starting at i_in_index (slots wrap
// modulo 64) at t = i_in_param_t / 2^16.
// Output channel (o_out_valid / i_out_ready): one beat per evaluation with the
// position, first and second derivative of x, y and z, each Q16.8 floored.
// Writes are taken one per cycle while no evaluation holds the input. An
// evaluation holds the input while its four control points are read one by
// one from the single-port point store; the next beat may be taken in the cycle
// they are handed to the arithmetic pipeline. Results leave in input order.
// Reset clears all points to zero at once through per-slot valid bits; the
// block takes beats from the first cycle after reset.
// When the receiver stalls, the result stays in the output register and the
// arithmetic pipeline holds; a sequencer that has gathered its points then
// keeps them and takes no beats until the pipeline moves again.
`default_nettype none

module cubic_bspline_evaluator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_in_mode,
    input  logic [bspl_pkg::IDX_W-1:0]          i_in_index,
    input  logic signed [bspl_pkg::COORD_W-1:0] i_in_point_x,
    input  logic signed [bspl_pkg::COORD_W-1:0] i_in_point_y,
    input  logic signed [bspl_pkg::COORD_W-1:0] i_in_point_z,
    input  logic [bspl_pkg::PARAM_W-1:0]        i_in_param_t,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_pos_x,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_pos_y,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_pos_z,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_slope_x,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_slope_y,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_slope_z,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_bend_x,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_bend_y,
    output logic signed [bspl_pkg::OUT_W-1:0]   o_bend_z
);

    bspl_pkg::t_mem_req  w_req;
    bspl_pkg::t_point    w_rdata;
    logic                w_rvld;
    bspl_pkg::t_point    w_point;
    bspl_pkg::t_seg      w_seg;
    logic                w_seg_ready;
    bspl_pkg::t_result   w_res;

    assign w_point = {i_in_point_z, i_in_point_y, i_in_point_x};

    bspl_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata),
        .o_rvld  (w_rvld)
    );

    bspl_fetch u_fetch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_in_mode),
        .i_index     (i_in_index),
        .i_point     (w_point),
        .i_param_t   (i_in_param_t),
        .o_req       (w_req),
        .i_rdata     (w_rdata),
        .i_rvld      (w_rvld),
        .o_seg       (w_seg),
        .i_seg_ready (w_seg_ready)
    );

    bspl_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (w_seg),
        .o_seg_ready (w_seg_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res)
    );

    assign o_pos_x   = w_res.pos[0];
    assign o_pos_y   = w_res.pos[1];
    assign o_pos_z   = w_res.pos[2];
    assign o_slope_x = w_res.slope[0];
    assign o_slope_y = w_res.slope[1];
    assign o_slope_z = w_res.slope[2];
    assign o_bend_x  = w_res.bend[0];
    assign o_bend_y  = w_res.bend[1];
    assign o_bend_z  = w_res.bend[2];

    // A gathered segment that the pipeline cannot take is held unchanged.
    a_seg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_seg.valid && !w_seg_ready) |=> (w_seg.valid && $stable(w_seg.pts)))
        else $error("gathered segment lost while pipeline stalled");

    // An evaluate beat blocks the input while its points are read.
    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_mode) |=> !o_in_ready)
        else $error("input taken during point reads");

    // No read and write of the store in the same cycle on its single port.
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req.re && w_req.we))
        else $error("point store read and written together");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== rtl/bspl_store.sv =====
// Control point store: one synchronous single-port memory with registered read.
// Per-entry valid bits flag never-written entries on o_rvld for the sequencer to read as zero. Uses bspl_pkg.
`default_nettype none

module bspl_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bspl_pkg::t_mem_req  i_req,
    output bspl_pkg::t_point    o_rdata,
    output logic                o_rvld
);

    bspl_pkg::t_point                     r_mem [bspl_pkg::MAX_POINTS];
    logic [bspl_pkg::MAX_POINTS-1:0]      r_wr;
    bspl_pkg::t_point                     r_rdata;
    logic                                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_wr[i_req.addr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvld <= r_wr[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_rvld  = r_rvld;

endmodule

`default_nettype wire

// ===== rtl/bspl_fetch.sv =====
// Input sequencer: takes write and evaluate beats, drives the point store port
// and gathers four control points per evaluation. Uses bspl_pkg.
`default_nettype none

module bspl_fetch (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [bspl_pkg::IDX_W-1:0]      i_index,
    input  bspl_pkg::t_point                i_point,
    input  logic [bspl_pkg::PARAM_W-1:0]    i_param_t,
    output bspl_pkg::t_mem_req              o_req,
    input  bspl_pkg::t_point                i_rdata,
    input  logic                            i_rvld,
    output bspl_pkg::t_seg                  o_seg,
    input  logic                            i_seg_ready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LAST = 3'b100
    } t_fstate;

    t_fstate                            r_state, n_state;
    logic [1:0]                         r_cnt, n_cnt;
    logic [bspl_pkg::ADDR_W-1:0]        r_base;
    logic [bspl_pkg::T_BITS-1:0]        r_t;
    bspl_pkg::t_point [2:0]             r_p;
    bspl_pkg::t_point                   w_rd;
    logic                               w_accept;
    logic                               w_open;

    // Entries never written read back as zero.
    assign w_rd = i_rvld ? i_rdata : '0;

    // The last read's data is handed over in the same cycle that a new beat
    // may be taken, so the next evaluation can start as the last one is handed over.
    assign w_open     = (r_state == S_IDLE) || ((r_state == S_LAST) && i_seg_ready);
    assign o_in_ready = w_open;
    assign w_accept   = i_in_valid && w_open;

    always_comb begin
        o_req.wdata = i_point;
        o_req.we    = w_accept && (i_mode == bspl_pkg::MODE_WRITE);
        if (r_state == S_READ) begin
            o_req.re   = 1'b1;
            o_req.addr = r_base + bspl_pkg::ADDR_W'(r_cnt);
        end else begin
            o_req.re   = w_accept && (i_mode == bspl_pkg::MODE_EVAL);
            o_req.addr = i_index[bspl_pkg::ADDR_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE, S_LAST: begin
                if (w_accept && (i_mode == bspl_pkg::MODE_EVAL)) begin
                    n_state = S_READ;
                    n_cnt   = 2'd1;
                end else if (w_open) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_LAST;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == bspl_pkg::MODE_EVAL)) begin
            r_base <= i_index[bspl_pkg::ADDR_W-1:0];
            r_t    <= i_param_t[bspl_pkg::T_BITS-1:0];
        end
        // Read data arrives in the cycle after its address, so count k holds point k-1.
        if (r_state == S_READ) begin
            r_p[r_cnt - 2'd1] <= w_rd;
        end
    end

    assign o_seg.valid = (r_state == S_LAST);
    assign o_seg.pts   = {w_rd, r_p[2], r_p[1], r_p[0]};
    assign o_seg.u     = r_t;

endmodule

`default_nettype wire

// ===== rtl/bspl_datapath.sv =====
// Evaluation pipeline: basis coefficients, Horner steps in t for the three
// polynomials of all axes, floor scaling and the output register. Uses bspl_pkg.
`default_nettype none

module bspl_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bspl_pkg::t_seg      i_seg,
    output logic                o_seg_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bspl_pkg::t_result   o_res
);

    localparam int STAGES = 9;
    localparam int NA     = bspl_pkg::N_AXES;
    localparam int CW     = bspl_pkg::C_W;
    localparam int OW     = bspl_pkg::OUT_W;
    localparam int TB     = bspl_pkg::T_BITS;

    logic [STAGES-1:0] r_vld;
    logic              w_en;

    logic signed [CW-1:0] w_pt [4][NA];
    logic signed [CW-1:0] w_lead [NA];
    logic signed [CW-1:0] w_cp1 [NA];
    logic signed [CW-1:0] w_cp2 [NA];
    logic signed [CW-1:0] w_cp3 [NA];
    logic signed [CW-1:0] w_cs1 [NA];
    logic signed [CW-1:0] w_cs2 [NA];
    logic signed [CW-1:0] w_cb1 [NA];
    logic signed [bspl_pkg::U_W-1:0] w_u;

    // Stage 0: coefficients.
    logic signed [CW-1:0] r0_lead [NA];
    logic signed [CW-1:0] r0_cp1 [NA];
    logic signed [CW-1:0] r0_cp2 [NA];
    logic signed [CW-1:0] r0_cp3 [NA];
    logic signed [CW-1:0] r0_cs1 [NA];
    logic signed [CW-1:0] r0_cs2 [NA];
    logic signed [CW-1:0] r0_cb1 [NA];
    logic signed [bspl_pkg::U_W-1:0] r0_u;
    // Stage 1: lead * t, shared by all three polynomials.
    logic signed [bspl_pkg::M1_W-1:0] r1_m1 [NA];
    logic signed [CW-1:0] r1_cp1 [NA];
    logic signed [CW-1:0] r1_cp2 [NA];
    logic signed [CW-1:0] r1_cp3 [NA];
    logic signed [CW-1:0] r1_cs1 [NA];
    logic signed [CW-1:0] r1_cs2 [NA];
    logic signed [CW-1:0] r1_cb1 [NA];
    logic signed [bspl_pkg::U_W-1:0] r1_u;
    // Stage 2: first Horner add; second derivative done.
    logic signed [bspl_pkg::A1_W-1:0] r2_a1p [NA];
    logic signed [bspl_pkg::A1_W-1:0] r2_a1s [NA];
    logic [OW-1:0] r2_bend [NA];
    logic signed [CW-1:0] r2_cp2 [NA];
    logic signed [CW-1:0] r2_cp3 [NA];
    logic signed [CW-1:0] r2_cs2 [NA];
    logic signed [bspl_pkg::U_W-1:0] r2_u;
    // Stage 3: second multiply.
    logic signed [bspl_pkg::M2_W-1:0] r3_m2p [NA];
    logic signed [bspl_pkg::M2_W-1:0] r3_m2s [NA];
    logic [OW-1:0] r3_bend [NA];
    logic signed [CW-1:0] r3_cp2 [NA];
    logic signed [CW-1:0] r3_cp3 [NA];
    logic signed [CW-1:0] r3_cs2 [NA];
    logic signed [bspl_pkg::U_W-1:0] r3_u;
    // Stage 4: second add; first derivative done.
    logic signed [bspl_pkg::A2_W-1:0] r4_a2p [NA];
    logic [OW-1:0] r4_slope [NA];
    logic [OW-1:0] r4_bend [NA];
    logic signed [CW-1:0] r4_cp3 [NA];
    logic signed [bspl_pkg::U_W-1:0] r4_u;
    // Stage 5: third multiply.
    logic signed [bspl_pkg::M3_W-1:0] r5_m3 [NA];
    logic [OW-1:0] r5_slope [NA];
    logic [OW-1:0] r5_bend [NA];
    logic signed [CW-1:0] r5_cp3 [NA];
    // Stage 6: offset position sum; stage 7: reciprocal product.
    logic [bspl_pkg::W_W-1:0] r6_w [NA];
    logic [OW-1:0] r6_slope [NA];
    logic [OW-1:0] r6_bend [NA];
    logic [bspl_pkg::Q_W-1:0] r7_q [NA];
    logic [OW-1:0] r7_slope [NA];
    logic [OW-1:0] r7_bend [NA];
    bspl_pkg::t_result r_out;

    logic signed [bspl_pkg::S2_W-1:0] w_s2 [NA];

    // The whole pipeline moves together; it halts only when a result waits.
    assign w_en        = !r_vld[STAGES-1] || i_out_ready;
    assign o_seg_ready = w_en;
    assign o_out_valid = r_vld[STAGES-1];
    assign o_res       = r_out;

    assign w_u = $signed({1'b0, i_seg.u});

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int a = 0; a < NA; a++) begin
                w_pt[k][a] = CW'($signed(i_seg.pts[k][a]));
            end
        end
        for (int a = 0; a < NA; a++) begin
            w_lead[a] = CW'(-w_pt[0][a] + 3 * w_pt[1][a] - 3 * w_pt[2][a] + w_pt[3][a]);
            w_cp1[a]  = CW'(3 * w_pt[0][a] - 6 * w_pt[1][a] + 3 * w_pt[2][a]);
            w_cp2[a]  = CW'(-3 * w_pt[0][a] + 3 * w_pt[2][a]);
            w_cp3[a]  = CW'(w_pt[0][a] + 4 * w_pt[1][a] + w_pt[2][a]);
            w_cs1[a]  = CW'(2 * w_pt[0][a] - 4 * w_pt[1][a] + 2 * w_pt[2][a]);
            w_cs2[a]  = CW'(-w_pt[0][a] + w_pt[2][a]);
            w_cb1[a]  = CW'(w_pt[0][a] - 2 * w_pt[1][a] + w_pt[2][a]);
        end
    end

    // Floor of the first derivative is an arithmetic shift by 2*T_BITS + 1.
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            w_s2[a] = bspl_pkg::S2_W'(r3_m2s[a])
                    + (bspl_pkg::S2_W'(r3_cs2[a]) <<< (2 * TB));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_seg.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_u <= w_u;
            r1_u <= r0_u;
            r2_u <= r1_u;
            r3_u <= r2_u;
            r4_u <= r3_u;
            for (int a = 0; a < NA; a++) begin
                r0_lead[a] <= w_lead[a];
                r0_cp1[a]  <= w_cp1[a];
                r0_cp2[a]  <= w_cp2[a];
                r0_cp3[a]  <= w_cp3[a];
                r0_cs1[a]  <= w_cs1[a];
                r0_cs2[a]  <= w_cs2[a];
                r0_cb1[a]  <= w_cb1[a];

                r1_m1[a]  <= r0_lead[a] * r0_u;
                r1_cp1[a] <= r0_cp1[a];
                r1_cp2[a] <= r0_cp2[a];
                r1_cp3[a] <= r0_cp3[a];
                r1_cs1[a] <= r0_cs1[a];
                r1_cs2[a] <= r0_cs2[a];
                r1_cb1[a] <= r0_cb1[a];

                r2_a1p[a]  <= bspl_pkg::A1_W'(r1_m1[a])
                            + (bspl_pkg::A1_W'(r1_cp1[a]) <<< TB);
                r2_a1s[a]  <= bspl_pkg::A1_W'(r1_m1[a])
                            + (bspl_pkg::A1_W'(r1_cs1[a]) <<< TB);
                r2_bend[a] <= OW'(r1_m1[a] >>> TB) + OW'(r1_cb1[a]);
                r2_cp2[a]  <= r1_cp2[a];
                r2_cp3[a]  <= r1_cp3[a];
                r2_cs2[a]  <= r1_cs2[a];

                r3_m2p[a]  <= r2_a1p[a] * r2_u;
                r3_m2s[a]  <= r2_a1s[a] * r2_u;
                r3_bend[a] <= r2_bend[a];
                r3_cp2[a]  <= r2_cp2[a];
                r3_cp3[a]  <= r2_cp3[a];
                r3_cs2[a]  <= r2_cs2[a];

                r4_a2p[a]   <= bspl_pkg::A2_W'(r3_m2p[a])
                             + (bspl_pkg::A2_W'(r3_cp2[a]) <<< (2 * TB));
                r4_slope[a] <= w_s2[a][bspl_pkg::S2_W-1 -: OW];
                r4_bend[a]  <= r3_bend[a];
                r4_cp3[a]   <= r3_cp3[a];

                r5_m3[a]    <= r4_a2p[a] * r4_u;
                r5_slope[a] <= r4_slope[a];
                r5_bend[a]  <= r4_bend[a];
                r5_cp3[a]   <= r4_cp3[a];

                // Only the low bits are kept; the true offset sum is known to fit.
                r6_w[a]     <= r5_m3[a][3 * TB +: bspl_pkg::W_W]
                             + bspl_pkg::W_W'(r5_cp3[a])
                             + bspl_pkg::W_W'(bspl_pkg::POS_OFF);
                r6_slope[a] <= r5_slope[a];
                r6_bend[a]  <= r5_bend[a];

                r7_q[a]     <= bspl_pkg::Q_W'(r6_w[a])
                             * bspl_pkg::Q_W'(bspl_pkg::RECIP);
                r7_slope[a] <= r6_slope[a];
                r7_bend[a]  <= r6_bend[a];

                r_out.pos[a]   <= OW'(r7_q[a][bspl_pkg::RECIP_SH +: bspl_pkg::Q_OUT_W])
                                - OW'(bspl_pkg::POS_BIAS);
                r_out.slope[a] <= r7_slope[a];
                r_out.bend[a]  <= r7_bend[a];
            end
        end
    end

endmodule

`default_nettype wire
